// ===== hw/rtl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and constants of the indexed min-heap: entry layout, position
// map layout, operation and status codes, stream widths.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int SCORE_BITS = 32;
    localparam int NODE_BITS  = 10;
    localparam int EDGE_BITS  = 12;
    localparam int POS_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS   = POS_BITS + 1;

    localparam int ENTRY_BITS = SCORE_BITS + NODE_BITS + EDGE_BITS;
    localparam int SLOT_BITS  = POS_BITS + 1;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;
    localparam logic [1:0] OP_LOOKUP  = 2'd3;

    // Status codes carried on the output tuser.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_BADPOS  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    // One heap entry as stored in the entry memory.
    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic [NODE_BITS-1:0]  node;
        logic [EDGE_BITS-1:0]  edge_tag;
    } t_entry;

    // One word of the node-to-position map.
    typedef struct packed {
        logic                present;
        logic [POS_BITS-1:0] pos;
    } t_slot;

    // Result fields collected while an operation runs.
    typedef struct packed {
        logic [2:0]            status;
        logic [SCORE_BITS-1:0] score;
        logic [NODE_BITS-1:0]  node;
        logic [EDGE_BITS-1:0]  edge_tag;
        logic [POS_BITS-1:0]   pos;
        logic                  present;
    } t_result;

endpackage

// ===== hw/rtl/imh_ram.sv =====
// ----------------------------------------------------------------------------
// imh_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/imh_cmp.sv =====
// ----------------------------------------------------------------------------
// imh_cmp
// Shared score comparator used by every sift step: flags a > b, unsigned.
// ----------------------------------------------------------------------------
module imh_cmp
    import imh_pkg::*;
(
    input  logic [SCORE_BITS-1:0] i_a,
    input  logic [SCORE_BITS-1:0] i_b,
    output logic                  o_gt
);

    // Strict unsigned compare; ties never move an entry.
    assign o_gt = (i_a > i_b);

endmodule

// ===== hw/rtl/indexed_min_heap.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap
// Binary min-heap of (score, node, edge) entries with a node-to-position map.
// A sequencer walks the heap one level at a time through the entry memory,
// using one shared comparator for every score decision.
//
//  Channel | Direction | Transfer when          | Payload
//  --------+-----------+------------------------+---------------------------
//  s_*     | in        | s_tvalid && s_tready   | op on tuser, fields on tdata
//  m_*     | out       | m_tvalid && m_tready   | status on tuser, rest on tdata
//
// Each request first checks the node map and the fill count. Insert then sifts
// up level by level; remove and extract fill the hole with the last entry and
// sift it up or down level by level. The single read port of the entry memory
// serialises the parent and child reads of every level. After reset a clearing
// pass marks every node absent; s_tready stays low meanwhile.
// A result waits in an output register; while it is not taken, the next
// request runs but cannot finish.
// ----------------------------------------------------------------------------
module indexed_min_heap
    import imh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] key_score, [41:32] node_id, [53:42] edge_tag, [63:54] heap_pos
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] out_score, [41:32] out_node, [53:42] out_edge, [63:54] out_pos,
    // [64] present, [75:65] fill_count, [79:76] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [2:0]            m_tuser
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_CHECK = 12'b0000_0000_0100,
        S_LAST  = 12'b0000_0000_1000,
        S_UP    = 12'b0000_0001_0000,
        S_UPCMP = 12'b0000_0010_0000,
        S_DN    = 12'b0000_0100_0000,
        S_DN1   = 12'b0000_1000_0000,
        S_DN2   = 12'b0001_0000_0000,
        S_DNCMP = 12'b0010_0000_0000,
        S_LOOK  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [1:0]            r_op, n_op;
    t_entry                r_key, n_key;
    logic [POS_BITS-1:0]   r_hpos, n_hpos;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [POS_BITS-1:0]   r_p, n_p;
    t_entry                r_cur, n_cur;
    t_entry                r_kid, n_kid;
    logic [POS_BITS-1:0]   r_kidpos, n_kidpos;
    logic                  r_rm, n_rm;
    logic                  r_moved, n_moved;
    logic [POS_BITS-1:0]   r_clr, n_clr;
    t_result               r_res, n_res;
    logic                  r_ov, n_ov;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;
    logic [2:0]            r_ouser, n_ouser;

    // Memory ports.
    logic                  hp_we;
    logic [POS_BITS-1:0]   hp_waddr, hp_raddr;
    t_entry                hp_wdata, hp_rd;
    logic                  mp_we;
    logic [POS_BITS-1:0]   mp_waddr, mp_raddr;
    t_slot                 mp_wdata, mp_rd;

    // Shared comparator.
    logic [SCORE_BITS-1:0] cmp_a, cmp_b;
    logic                  cmp_gt;

    // Helpers.
    logic                  in_xfer;
    logic [CNT_BITS-1:0]   last, c1, c2;
    logic [POS_BITS-1:0]   start_p;

    imh_ram #(.P_WIDTH(ENTRY_BITS), .P_DEPTH(MAX_NODES)) u_heap (
        .i_clk   (i_clk),
        .i_we    (hp_we),
        .i_waddr (hp_waddr),
        .i_wdata (hp_wdata),
        .i_raddr (hp_raddr),
        .o_rdata (hp_rd)
    );

    imh_ram #(.P_WIDTH(SLOT_BITS), .P_DEPTH(MAX_NODES)) u_map (
        .i_clk   (i_clk),
        .i_we    (mp_we),
        .i_waddr (mp_waddr),
        .i_wdata (mp_wdata),
        .i_raddr (mp_raddr),
        .o_rdata (mp_rd)
    );

    imh_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt)
    );

    assign s_tready = (r_state == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = r_ov;
    assign m_tdata  = r_odata;
    assign m_tuser  = r_ouser;

    assign last    = r_count - CNT_BITS'(1);
    assign c1      = {r_p, 1'b1};
    assign c2      = {1'b0, r_kidpos} + CNT_BITS'(1);
    assign start_p = (r_op == OP_EXTRACT) ? '0 : r_hpos;

    // Comparator operand selection per sift step.
    always_comb begin
        cmp_a = r_cur.score;
        cmp_b = r_kid.score;
        unique case (r_state)
            S_UPCMP: begin
                cmp_a = hp_rd.score;
                cmp_b = r_cur.score;
            end
            S_DN2: begin
                cmp_a = r_kid.score;
                cmp_b = hp_rd.score;
            end
            default: begin
                cmp_a = r_cur.score;
                cmp_b = r_kid.score;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_hpos   = r_hpos;
        n_count  = r_count;
        n_p      = r_p;
        n_cur    = r_cur;
        n_kid    = r_kid;
        n_kidpos = r_kidpos;
        n_rm     = r_rm;
        n_moved  = r_moved;
        n_clr    = r_clr;
        n_res    = r_res;
        n_ov     = r_ov;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        hp_we    = 1'b0;
        hp_waddr = r_p;
        hp_wdata = r_cur;
        hp_raddr = '0;
        mp_we    = 1'b0;
        mp_waddr = r_cur.node;
        mp_wdata = '{present: 1'b1, pos: r_p};
        mp_raddr = '0;

        // The output register empties on a transfer.
        if (r_ov && m_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mp_we    = 1'b1;
                mp_waddr = r_clr;
                mp_wdata = '0;
                n_clr    = r_clr + POS_BITS'(1);
                if (r_clr == POS_BITS'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mp_raddr = s_tdata[41:32];
                hp_raddr = (s_tuser == OP_EXTRACT) ? '0 : s_tdata[63:54];
                if (in_xfer) begin
                    n_op    = s_tuser;
                    n_key   = '{score: s_tdata[31:0], node: s_tdata[41:32],
                                edge_tag: s_tdata[53:42]};
                    n_hpos  = s_tdata[63:54];
                    n_res   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (r_op)
                    OP_INSERT: begin
                        if (mp_rd.present) begin
                            n_res.status = ST_PRESENT;
                            n_state      = S_DONE;
                        end else if (r_count >= CNT_BITS'(MAX_NODES)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_cur   = r_key;
                            n_p     = r_count[POS_BITS-1:0];
                            n_count = r_count + CNT_BITS'(1);
                            n_rm    = 1'b0;
                            n_moved = 1'b0;
                            n_state = S_UP;
                        end
                    end
                    OP_LOOKUP: begin
                        n_res.node = r_key.node;
                        if (mp_rd.present) begin
                            n_res.present = 1'b1;
                            n_res.pos     = mp_rd.pos;
                            hp_raddr      = mp_rd.pos;
                            n_state       = S_LOOK;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else if (r_op == OP_REMOVE &&
                                     {1'b0, r_hpos} >= r_count) begin
                            n_res.status = ST_BADPOS;
                            n_state      = S_DONE;
                        end else begin
                            if (r_op == OP_EXTRACT) begin
                                n_res.score    = hp_rd.score;
                                n_res.node     = hp_rd.node;
                                n_res.edge_tag = hp_rd.edge_tag;
                            end
                            // The removed node leaves the map.
                            mp_we    = 1'b1;
                            mp_waddr = hp_rd.node;
                            mp_wdata = '0;
                            n_count  = last;
                            n_p      = start_p;
                            n_rm     = 1'b1;
                            n_moved  = 1'b0;
                            if ({1'b0, start_p} == last) begin
                                n_state = S_DONE;
                            end else begin
                                hp_raddr = last[POS_BITS-1:0];
                                n_state  = S_LAST;
                            end
                        end
                    end
                endcase
            end
            S_LAST: begin
                // The last entry fills the hole.
                n_cur   = hp_rd;
                n_state = S_UP;
            end
            S_UP: begin
                if (r_p == '0) begin
                    if (r_rm && !r_moved) begin
                        n_state = S_DN;
                    end else begin
                        hp_we   = 1'b1;
                        mp_we   = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    hp_raddr = (r_p - POS_BITS'(1)) >> 1;
                    n_kidpos = (r_p - POS_BITS'(1)) >> 1;
                    n_state  = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (cmp_gt) begin
                    // Parent moves down into the hole.
                    hp_we    = 1'b1;
                    hp_wdata = hp_rd;
                    mp_we    = 1'b1;
                    mp_waddr = hp_rd.node;
                    n_p      = r_kidpos;
                    n_moved  = 1'b1;
                    n_state  = S_UP;
                end else if (r_rm && !r_moved) begin
                    n_state = S_DN;
                end else begin
                    hp_we   = 1'b1;
                    mp_we   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DN: begin
                if (c1 >= r_count) begin
                    hp_we   = 1'b1;
                    mp_we   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    hp_raddr = c1[POS_BITS-1:0];
                    n_kidpos = c1[POS_BITS-1:0];
                    n_state  = S_DN1;
                end
            end
            S_DN1: begin
                n_kid = hp_rd;
                if (c2 < r_count) begin
                    hp_raddr = c2[POS_BITS-1:0];
                    n_state  = S_DN2;
                end else begin
                    n_state = S_DNCMP;
                end
            end
            S_DN2: begin
                // Right child wins only when strictly smaller.
                if (cmp_gt) begin
                    n_kid    = hp_rd;
                    n_kidpos = c2[POS_BITS-1:0];
                end
                n_state = S_DNCMP;
            end
            S_DNCMP: begin
                if (cmp_gt) begin
                    hp_we    = 1'b1;
                    hp_wdata = r_kid;
                    mp_we    = 1'b1;
                    mp_waddr = r_kid.node;
                    n_p      = r_kidpos;
                    n_state  = S_DN;
                end else begin
                    hp_we   = 1'b1;
                    mp_we   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_LOOK: begin
                n_res.score    = hp_rd.score;
                n_res.edge_tag = hp_rd.edge_tag;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || m_tready) begin
                    n_ov    = 1'b1;
                    n_ouser = r_res.status;
                    n_odata = {4'b0, r_count, r_res.present, r_res.pos,
                               r_res.edge_tag, r_res.node, r_res.score};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_rm    <= 1'b0;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_rm    <= n_rm;
            r_moved <= n_moved;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_hpos   <= n_hpos;
        r_p      <= n_p;
        r_cur    <= n_cur;
        r_kid    <= n_kid;
        r_kidpos <= n_kidpos;
        r_res    <= n_res;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_NODES))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CNT_BITS'(1)
             || r_count + CNT_BITS'(1) == $past(r_count)))
        else $error("entry count moved by more than one");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CHECK))
        else $error("accepted request did not start");

    a_sift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPCMP || r_state == S_DNCMP) |-> ({1'b0, r_p} < r_count))
        else $error("sift position outside the heap");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed min-heap. A software heap with its own
// node map predicts every result; requests and results move over the two
// stream ports with random gaps and stalls, and each result is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import imh_pkg::*;

    // Expected result of one request.
    typedef struct packed {
        logic [2:0]            status;
        logic [SCORE_BITS-1:0] score;
        logic [NODE_BITS-1:0]  node;
        logic [EDGE_BITS-1:0]  edge_tag;
        logic [POS_BITS-1:0]   pos;
        logic                  present;
        logic [CNT_BITS-1:0]   fill;
    } t_heap_result;

    // Software heap that predicts each result and checks what the block returns.
    class heap_scoreboard;
        logic [SCORE_BITS-1:0] score_q[MAX_NODES];
        logic [NODE_BITS-1:0]  node_q[MAX_NODES];
        logic [EDGE_BITS-1:0]  edge_q[MAX_NODES];
        int                    where_is[MAX_NODES];
        bit                    is_in[MAX_NODES];
        int                    count;
        t_heap_result          pending[$];
        int                    errors;
        int                    checked;

        function new();
            count = 0;
            errors = 0;
            checked = 0;
            foreach (is_in[i]) is_in[i] = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic [SCORE_BITS-1:0] s;
            logic [NODE_BITS-1:0]  n;
            logic [EDGE_BITS-1:0]  e;
            s = score_q[a]; n = node_q[a]; e = edge_q[a];
            score_q[a] = score_q[b]; node_q[a] = node_q[b]; edge_q[a] = edge_q[b];
            score_q[b] = s; node_q[b] = n; edge_q[b] = e;
            where_is[node_q[a]] = a;
            where_is[node_q[b]] = b;
        endfunction

        function int bubble_up(int p);
            int parent;
            while (p > 0) begin
                parent = (p - 1) / 2;
                if (score_q[parent] > score_q[p]) begin
                    swap_slots(p, parent);
                    p = parent;
                end else begin
                    break;
                end
            end
            return p;
        endfunction

        function void bubble_down(int p);
            int c1;
            int pick;
            forever begin
                c1 = 2 * p + 1;
                if (c1 >= count) break;
                pick = c1;
                if (c1 + 1 < count && score_q[c1 + 1] < score_q[c1]) pick = c1 + 1;
                if (score_q[p] > score_q[pick]) begin
                    swap_slots(p, pick);
                    p = pick;
                end else begin
                    break;
                end
            end
        endfunction

        // The last entry fills the hole, then moves whichever way it must.
        function void take_out(int p);
            int last;
            last = count - 1;
            is_in[node_q[p]] = 0;
            count = last;
            if (p != last) begin
                score_q[p] = score_q[last];
                node_q[p] = node_q[last];
                edge_q[p] = edge_q[last];
                where_is[node_q[p]] = p;
                if (bubble_up(p) == p) bubble_down(p);
            end
        endfunction

        // Note an accepted request and queue its expected result.
        function void note_request(logic [1:0] op, logic [SCORE_BITS-1:0] sc,
                                   logic [NODE_BITS-1:0] nd,
                                   logic [EDGE_BITS-1:0] ed,
                                   logic [POS_BITS-1:0] hp);
            t_heap_result r;
            r = '{status: ST_OK, score: '0, node: '0, edge_tag: '0, pos: '0,
                  present: 1'b0, fill: '0};
            case (op)
                OP_INSERT: begin
                    if (is_in[nd]) begin
                        r.status = ST_PRESENT;
                    end else if (count >= MAX_NODES) begin
                        r.status = ST_FULL;
                    end else begin
                        score_q[count] = sc;
                        node_q[count] = nd;
                        edge_q[count] = ed;
                        where_is[nd] = count;
                        is_in[nd] = 1;
                        count++;
                        void'(bubble_up(count - 1));
                    end
                end
                OP_REMOVE: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (hp >= count) r.status = ST_BADPOS;
                    else take_out(hp);
                end
                OP_EXTRACT: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.score = score_q[0];
                        r.node = node_q[0];
                        r.edge_tag = edge_q[0];
                        take_out(0);
                    end
                end
                default: begin
                    r.node = nd;
                    if (is_in[nd]) begin
                        r.score = score_q[where_is[nd]];
                        r.edge_tag = edge_q[where_is[nd]];
                        r.pos = POS_BITS'(where_is[nd]);
                        r.present = 1'b1;
                    end
                end
            endcase
            r.fill = CNT_BITS'(count);
            pending = {pending, r};
        endfunction

        // Compare one result with the oldest expectation.
        function void check_result(logic [2:0] st, logic [OUT_DATA_W-1:0] d);
            t_heap_result e;
            t_heap_result a;
            a.status = st;
            a.score = d[31:0];
            a.node = d[41:32];
            a.edge_tag = d[53:42];
            a.pos = d[63:54];
            a.present = d[64];
            a.fill = d[75:65];
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d data %h",
                         $time, st, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a !== e || d[79:76] !== 4'b0) begin
                $display("%0t: mismatch expected st=%0d sc=%h nd=%0d ed=%0d pos=%0d pr=%0d fc=%0d",
                         $time, e.status, e.score, e.node, e.edge_tag, e.pos,
                         e.present, e.fill);
                $display("%0t:          actual   st=%0d sc=%h nd=%0d ed=%0d pos=%0d pr=%0d fc=%0d",
                         $time, a.status, a.score, a.node, a.edge_tag, a.pos,
                         a.present, a.fill);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    heap_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             quiet_cycles;
    int             phase_items[4];

    indexed_min_heap dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sink side: random stalls, check every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no transfer on either side; covers the clearing pass.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Send one request and hold it until the transfer.
    task automatic send_request(logic [1:0] op, logic [SCORE_BITS-1:0] sc,
                                logic [NODE_BITS-1:0] nd, logic [EDGE_BITS-1:0] ed,
                                logic [POS_BITS-1:0] hp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {hp, ed, nd, sc};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_request(op, sc, nd, ed, hp);
    endtask

    // Random request, mostly well formed against the current heap contents.
    task automatic send_random(int mix);
        logic [1:0]       op;
        logic [NODE_BITS-1:0] nd;
        logic [POS_BITS-1:0] hp;
        int               k;
        k = $urandom_range(99);
        if (k < mix) op = OP_INSERT;
        else if (k < mix + 15) op = OP_REMOVE;
        else if (k < mix + 35) op = OP_EXTRACT;
        else op = OP_LOOKUP;
        // Small node space so duplicates and hits happen often.
        nd = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(63));
        if (sb.count > 0 && $urandom_range(9) != 0)
            hp = POS_BITS'($urandom_range(sb.count - 1));
        else hp = 10'($urandom);
        send_request(op, ($urandom_range(3) == 0) ? $urandom : $urandom_range(31),
                     nd, 12'($urandom), hp);
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        m_tready = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty heap errors, extremes of every field, ties, duplicates.
        send_request(OP_EXTRACT, '0, '0, '0, '0);
        send_request(OP_REMOVE, '0, '0, '0, '0);
        send_request(OP_LOOKUP, '0, 10'd1023, '0, '0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 10'd1023, 12'hFFF, 10'h3FF);
        send_request(OP_INSERT, 32'd0, 10'd0, 12'd0, '0);
        send_request(OP_INSERT, 32'd0, 10'd5, 12'd5, '0);
        send_request(OP_INSERT, 32'd7, 10'd0, 12'd9, '0);
        send_request(OP_INSERT, 32'd100, 10'd6, 12'd6, '0);
        send_request(OP_INSERT, 32'd50, 10'd7, 12'd7, '0);
        send_request(OP_INSERT, 32'd3, 10'd8, 12'd8, '0);
        send_request(OP_LOOKUP, '0, 10'd1023, '0, '0);
        send_request(OP_LOOKUP, '0, 10'd8, '0, '0);
        send_request(OP_LOOKUP, '0, 10'd9, '0, '0);
        send_request(OP_REMOVE, '0, '0, '0, 10'h3FF);
        send_request(OP_REMOVE, '0, '0, '0, 10'd6);
        send_request(OP_REMOVE, '0, '0, '0, 10'd4);
        send_request(OP_REMOVE, '0, '0, '0, 10'd1);
        repeat (5) send_request(OP_EXTRACT, '0, '0, '0, '0);

        // Random phases with different idle and stall mixes.
        phase_items = '{140, 120, 120, 120};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 33 : 59) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 33 : 59) : 0;
            for (int i = 0; i < phase_items[ph]; i++) send_random((ph % 2) ? 45 : 55);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("testbench: %0d results checked over directed cases and four handshake",
                 sb.checked);
        $display("mixes of random requests with idle sender and stalling receiver.");
        if (sb.errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end
endmodule
